/* rtl/core/dmxr_pkg.sv */
// ----------------------------------------------------------------------------
// DMX512 slot receiver package
// Shared constants, receiver phase encoding and the per-word result record.
// ----------------------------------------------------------------------------
package dmxr_pkg;

  localparam int CHANNELS   = 16;
  localparam int CH_IDX_W   = 4;
  localparam int SLOT_W     = 9;
  localparam int DATA_W     = 8;

  localparam logic [SLOT_W-1:0] SLOT_ONE   = SLOT_W'(1);
  localparam logic [SLOT_W-1:0] CH_COUNT   = SLOT_W'(CHANNELS);
  localparam logic [DATA_W-1:0] START_CODE = '0;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_BREAK = 2'd1,
    PH_SKIP  = 2'd2,
    PH_DATA  = 2'd3
  } phase_t;

  typedef struct packed {
    logic                write_valid;
    logic [CH_IDX_W-1:0] channel_index;
    logic [DATA_W-1:0]   channel_value;
    logic                value_changed;
    logic [CHANNELS-1:0] changed_mask;
    phase_t              receiver_state;
  } dmxr_result_t;

endpackage

/* rtl/core/dmxr_slot_fsm.sv */
// ----------------------------------------------------------------------------
// DMX512 slot sequencer
// Tracks break, start code and slot count, and owns the channel store and the
// sticky changed mask. State advances on step; the result is combinational.
// ----------------------------------------------------------------------------
module dmxr_slot_fsm import dmxr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [DATA_W-1:0]  rx_byte,
  input  logic               frame_error,
  input  logic [SLOT_W-1:0]  start_address,
  output dmxr_result_t       result
);

  phase_t              phase, phase_next;
  logic [SLOT_W-1:0]   slot_counter, slot_counter_next;
  logic [DATA_W-1:0]   channel_store [CHANNELS];
  logic [CHANNELS-1:0] new_flags, new_flags_next;
  logic [CH_IDX_W-1:0] idx;
  logic                capture;
  logic                changed;

  // Next phase and slot count.
  always_comb begin
    phase_next        = phase;
    slot_counter_next = slot_counter;
    if (frame_error) begin
      phase_next = PH_BREAK;
    end else begin
      case (phase)
        PH_BREAK: begin
          if (rx_byte != START_CODE) begin
            phase_next = PH_IDLE;
          end else begin
            slot_counter_next = start_address - SLOT_ONE;
            phase_next = (start_address == SLOT_ONE) ? PH_DATA : PH_SKIP;
          end
        end
        PH_SKIP: begin
          slot_counter_next = slot_counter - SLOT_ONE;
          if (slot_counter == SLOT_ONE) begin
            phase_next = PH_DATA;
          end
        end
        PH_DATA: begin
          slot_counter_next = slot_counter + SLOT_ONE;
          if (slot_counter_next >= CH_COUNT) begin
            phase_next = PH_IDLE;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  // Capture decision and result word.
  always_comb begin
    idx            = slot_counter[CH_IDX_W-1:0];
    capture        = !frame_error && (phase == PH_DATA);
    changed        = capture && (channel_store[idx] != rx_byte);
    new_flags_next = new_flags;
    if (changed) begin
      new_flags_next[idx] = 1'b1;
    end
    result.write_valid    = capture;
    result.channel_index  = capture ? idx : '0;
    result.channel_value  = capture ? rx_byte : '0;
    result.value_changed  = changed;
    result.changed_mask   = new_flags_next;
    result.receiver_state = phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      slot_counter <= '0;
      new_flags    <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        channel_store[i] <= '0;
      end
    end else if (step) begin
      phase        <= phase_next;
      slot_counter <= slot_counter_next;
      new_flags    <= new_flags_next;
      if (changed) begin
        channel_store[idx] <= rx_byte;
      end
    end
  end

endmodule

/* rtl/core/dmx512_slot_receiver.sv */
// ----------------------------------------------------------------------------
// DMX512 slot receiver
// Follows break and start code, skips to the start address and captures a
// block of channel values, reporting one result word per received byte.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Payload
//  rx        rx_valid / rx_stall    rx_byte, frame_error
//  res       res_valid / res_stall  write_valid, channel_index, channel_value,
//                                   value_changed, changed_mask, receiver_state
//  cfg       cfg_valid / cfg_ready  cfg_data (start address)
//
// Each byte is taken into the input register and then evaluated into the
// result register; one word per cycle is sustained while res does not stall.
// The sequencer state and channel store step as a word moves into the result
// register. A stall on res holds the result and backs up into the input
// register and then onto rx_stall.
// Reset clears the channel store and changed mask and sets start address 1.
// ----------------------------------------------------------------------------
module dmx512_slot_receiver import dmxr_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [SLOT_W-1:0]   cfg_data,
  input  logic                rx_valid,
  output logic                rx_stall,
  input  logic [DATA_W-1:0]   rx_byte,
  input  logic                frame_error,
  output logic                res_valid,
  input  logic                res_stall,
  output logic                write_valid,
  output logic [CH_IDX_W-1:0] channel_index,
  output logic [DATA_W-1:0]   channel_value,
  output logic                value_changed,
  output logic [CHANNELS-1:0] changed_mask,
  output logic [1:0]          receiver_state
);

  logic [SLOT_W-1:0] start_address;
  logic              hold_valid;
  logic [DATA_W-1:0] hold_byte;
  logic              hold_fe;
  logic              advance;
  logic              accept;
  dmxr_result_t      result;
  dmxr_result_t      res_word;

  assign cfg_ready = 1'b1;
  assign advance   = hold_valid && (!res_valid || !res_stall);
  assign rx_stall  = hold_valid && !advance;
  assign accept    = rx_valid && !rx_stall;

  // A start address of zero is repaired to one.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_address <= SLOT_ONE;
    end else if (cfg_valid && cfg_ready) begin
      start_address <= (cfg_data == '0) ? SLOT_ONE : cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_byte <= rx_byte;
      hold_fe   <= frame_error;
    end
  end

  dmxr_slot_fsm u_fsm (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .rx_byte       (hold_byte),
    .frame_error   (hold_fe),
    .start_address (start_address),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_word <= result;
    end
  end

  assign write_valid    = res_word.write_valid;
  assign channel_index  = res_word.channel_index;
  assign channel_value  = res_word.channel_value;
  assign value_changed  = res_word.value_changed;
  assign changed_mask   = res_word.changed_mask;
  assign receiver_state = res_word.receiver_state;

endmodule

/* rtl/core/dmxr_checker.sv */
// ----------------------------------------------------------------------------
// DMX512 slot receiver checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module dmxr_checker import dmxr_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                res_valid,
  input logic                res_stall,
  input logic                write_valid,
  input logic [CH_IDX_W-1:0] channel_index,
  input logic [DATA_W-1:0]   channel_value,
  input logic                value_changed,
  input logic [CHANNELS-1:0] changed_mask,
  input logic [1:0]          receiver_state
);

  logic [CHANNELS-1:0] last_mask;

  // Mask of the last word taken; changed bits must never fall.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_mask <= '0;
    end else if (res_valid && !res_stall) begin
      last_mask <= changed_mask;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(changed_mask)
      && $stable(channel_value) && $stable(receiver_state))
    else $error("stalled result word changed");

  a_quiet: assert property (@(posedge clk) disable iff (rst)
    res_valid && !write_valid |->
      channel_index == '0 && channel_value == '0 && !value_changed)
    else $error("capture fields set on a word that was not captured");

  a_state: assert property (@(posedge clk) disable iff (rst)
    res_valid && write_valid |->
      receiver_state == PH_DATA || receiver_state == PH_IDLE)
    else $error("captured word left an impossible state");

  a_sticky: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (changed_mask & last_mask) == last_mask)
    else $error("changed mask lost a bit");

  a_flag: assert property (@(posedge clk) disable iff (rst)
    res_valid && value_changed |-> changed_mask[channel_index])
    else $error("changed value without its mask bit");

endmodule

bind dmx512_slot_receiver dmxr_checker u_dmxr_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (res_valid),
  .res_stall      (res_stall),
  .write_valid    (write_valid),
  .channel_index  (channel_index),
  .channel_value  (channel_value),
  .value_changed  (value_changed),
  .changed_mask   (changed_mask),
  .receiver_state (receiver_state)
);
